// File: sv/fcpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpf_pkg
// Shared types, constants and helpers of the fingerprint command packet framer.
// ----------------------------------------------------------------------------
package fcpf_pkg;

  // Limit on parameter bytes in one packet. Larger counts are clipped to it.
  localparam int MaxParams = 32;

  localparam int CntW  = 6;   // Width of the param_count field.
  localparam int LenW  = 8;   // Length value, count plus three, always fits a byte.
  localparam int SumW  = 16;  // Width of the packet checksum.
  localparam int AddrW = 32;  // Width of the device address register.

  localparam logic [7:0]       HdrHi     = 8'hEF;
  localparam logic [7:0]       HdrLo     = 8'h01;
  localparam logic [7:0]       CmdFlag   = 8'h01;
  localparam logic [7:0]       LenHiByte = 8'h00;
  localparam logic [AddrW-1:0] AddrReset = 32'hFFFF_FFFF;

  // Header bytes are indexed from the first header byte to the command byte.
  localparam int              HdrIdxW = 4;
  localparam logic [HdrIdxW-1:0] HdrFirstAfterStart = 4'd1;
  localparam logic [HdrIdxW-1:0] HdrLast            = 4'd9;

  // Command queue between front and back.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  typedef enum logic {
    OP_START = 1'b0,
    OP_PARAM = 1'b1
  } fcpf_op_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HDR    = 4'b0010,
    S_SUM_HI = 4'b0100,
    S_SUM_LO = 4'b1000
  } fcpf_state_e;

  // One queued command. For a start, data is the command code and len the
  // length field. For a parameter, data is the byte itself. close asks the
  // back end to append the checksum, whose value travels along in sum.
  typedef struct packed {
    logic            is_start;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic            close;
    logic [SumW-1:0] sum;
  } fcpf_cmd_t;

  // Byte of the packet header at a given position.
  function automatic logic [7:0] hdr_byte(
    input logic [HdrIdxW-1:0] idx,
    input logic [AddrW-1:0]   addr,
    input logic [LenW-1:0]    len,
    input logic [7:0]         cmd
  );
    logic [7:0] b;
    case (idx)
      4'd0:    b = HdrHi;
      4'd1:    b = HdrLo;
      4'd2:    b = addr[31:24];
      4'd3:    b = addr[23:16];
      4'd4:    b = addr[15:8];
      4'd5:    b = addr[7:0];
      4'd6:    b = CmdFlag;
      4'd7:    b = LenHiByte;
      4'd8:    b = len;
      4'd9:    b = cmd;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/fingerprint_command_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fingerprint_command_packet_framer
// Frames command packets for a serial fingerprint module as a byte stream.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o) takes one beat per cycle unless
// the command queue is full. A start beat (operation 0) carries the command
// code and the parameter count, parameter beats (operation 1) one byte each.
// Parameter beats with no packet open are dropped. Counts above the limit are clipped.
// The output channel (out_valid_o / out_ready_i) moves one packet byte per
// beat; last_of_packet_o marks the low checksum byte.
// The configuration channel writes the 32-bit device address; cfg_ready_o is
// always high. Write it only while the block is idle.
// With an idle serializer, the first byte of a beat passes through the command
// queue and then the output register, where it can be taken at the next edge.
// Throughput: the serializer emits one byte per cycle unless the receiver stalls,
// so a start yields ten bytes (twelve with the checksum) and a parameter byte
// one (three when it closes the packet). The output byte rate, not the input
// side, sets the sustained rate; a four-entry command queue absorbs header bursts.
// When the receiver stalls, the byte in the output register holds, the queue
// fills, and then in_ready_o drops. Reset closes any packet, clears the
// checksum, empties the queue and sets the address to all ones.
// ----------------------------------------------------------------------------
module fingerprint_command_packet_framer
  import fcpf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AddrW-1:0] cfg_data_i,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [7:0]       byte_value_i,
  input  logic [CntW-1:0]  param_count_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             last_of_packet_o
);

  logic [AddrW-1:0] dev_addr_q;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  fcpf_cmd_t        q_wdata;
  fcpf_cmd_t        q_rdata;

  // Device address register. The user must write it only while no packet is in flight;
  // the block itself does not enforce this, and the serializer reads it directly while it walks the header.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= AddrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  // Front end: classifies beats, keeps the packet state and running checksum.
  fcpf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .byte_value_i  (byte_value_i),
    .param_count_i (param_count_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (q_wdata)
  );

  // Command queue between the two halves.
  fcpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: expands each command into packet bytes.
  fcpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (q_rdata),
    .pop_o       (q_pop),
    .dev_addr_i  (dev_addr_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_of_packet_o)
  );

  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("framer: push into full command queue");

endmodule

// File: sv/fcpf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpf_fifo
// Small command queue that decouples the classifying front from the serializer.
// ----------------------------------------------------------------------------
module fcpf_fifo
  import fcpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fcpf_cmd_t wdata_i,
  input  logic      pop_i,
  output fcpf_cmd_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  fcpf_cmd_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (FifoPtrW + 1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // The fill level never exceeds the depth, and a pop never hits an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FifoPtrW + 1)'(FifoDepth))
    else $error("fcpf_fifo: fill level above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("fcpf_fifo: pop from empty queue");

endmodule

// File: sv/fcpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpf_front
// Accepts input beats, tracks the open packet and its checksum, queues commands.
// ----------------------------------------------------------------------------
module fcpf_front
  import fcpf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            operation_i,
  input  logic [7:0]      byte_value_i,
  input  logic [CntW-1:0] param_count_i,
  input  logic            q_full_i,
  output logic            push_o,
  output fcpf_cmd_t       cmd_o
);

  logic            open_q, open_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [SumW-1:0] sum_q, sum_d;

  logic            accept;
  logic [CntW-1:0] cnt_sat;
  logic [LenW-1:0] len;
  logic [SumW-1:0] start_sum;
  logic [SumW-1:0] param_sum;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_sat   = (int'(param_count_i) > MaxParams) ? CntW'(MaxParams) : param_count_i;
  assign len       = LenW'(cnt_sat) + LenW'(3);
  assign start_sum = SumW'(CmdFlag) + SumW'(LenHiByte) + SumW'(len) + SumW'(byte_value_i);
  assign param_sum = sum_q + SumW'(byte_value_i);

  always_comb begin
    open_d         = open_q;
    rem_d          = rem_q;
    sum_d          = sum_q;
    push_o         = 1'b0;
    cmd_o.is_start = (operation_i == OP_START);
    cmd_o.data     = byte_value_i;
    cmd_o.len      = len;
    cmd_o.close    = 1'b0;
    cmd_o.sum      = start_sum;
    if (accept) begin
      if (operation_i == OP_START) begin
        // A start abandons any open packet and begins a new one.
        push_o      = 1'b1;
        cmd_o.close = (cnt_sat == '0);
        sum_d       = start_sum;
        open_d      = (cnt_sat != '0);
        rem_d       = cnt_sat;
      end else if (open_q) begin
        push_o      = 1'b1;
        cmd_o.sum   = param_sum;
        cmd_o.close = (rem_q == CntW'(1));
        sum_d       = param_sum;
        rem_d       = rem_q - 1'b1;
        open_d      = (rem_q != CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= '0;
      sum_q  <= '0;
    end else begin
      open_q <= open_d;
      rem_q  <= rem_d;
      sum_q  <= sum_d;
    end
  end

  // An open packet always still expects at least one parameter byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (rem_q != '0))
    else $error("fcpf_front: open packet with nothing left to receive");

endmodule

// File: sv/fcpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpf_back
// Serializes queued commands into packet bytes through a registered output.
// ----------------------------------------------------------------------------
module fcpf_back
  import fcpf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  fcpf_cmd_t        head_i,
  output logic             pop_o,
  input  logic [AddrW-1:0] dev_addr_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             last_o
);

  fcpf_state_e        state_q, state_d;
  logic [HdrIdxW-1:0] idx_q, idx_d;
  fcpf_cmd_t          cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic               load;

  // The output register takes a new beat when it is empty or being drained.
  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (load) begin
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            pop_o       = 1'b1;
            cur_d       = head_i;
            out_valid_d = 1'b1;
            last_d      = 1'b0;
            if (head_i.is_start) begin
              byte_d  = HdrHi;
              idx_d   = HdrFirstAfterStart;
              state_d = S_HDR;
            end else begin
              byte_d  = head_i.data;
              state_d = head_i.close ? S_SUM_HI : S_IDLE;
            end
          end
        end
        S_HDR: begin
          out_valid_d = 1'b1;
          last_d      = 1'b0;
          byte_d      = hdr_byte(idx_q, dev_addr_i, cur_q.len, cur_q.data);
          if (idx_q == HdrLast) begin
            state_d = cur_q.close ? S_SUM_HI : S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        S_SUM_HI: begin
          out_valid_d = 1'b1;
          last_d      = 1'b0;
          byte_d      = cur_q.sum[15:8];
          state_d     = S_SUM_LO;
        end
        S_SUM_LO: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          byte_d      = cur_q.sum[7:0];
          state_d     = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = byte_q;
  assign last_o      = last_q;

  // The header walk never starts at the first byte, which leaves from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HDR) |-> (idx_q >= HdrFirstAfterStart && idx_q <= HdrLast))
    else $error("fcpf_back: header index out of range");

  // The closing byte is always followed by a return to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM_LO && load) |=> (state_q == S_IDLE && last_q && out_valid_q))
    else $error("fcpf_back: checksum low byte not marked last");

endmodule

// File: bench/tb_fingerprint_command_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fingerprint_command_packet_framer
// Self-checking bench for the fingerprint command packet framer.
// ----------------------------------------------------------------------------
// The bench frames every accepted input beat in its own model, queues the
// packet bytes it expects, and checks each output beat against the oldest one.
// A short directed run covers zero counts, stray and abandoned parameters and
// clipped counts. Random traffic then follows under several device addresses.
// Both channels see random gaps, mostly short, a few long.
// ----------------------------------------------------------------------------
module tb_fingerprint_command_packet_framer;
  import fcpf_pkg::*;

  // One input beat as the driver presents it.
  typedef struct {
    fcpf_op_e        op;
    logic [7:0]      val;
    logic [CntW-1:0] cnt;
  } framer_beat_t;

  // One packet byte as the receiver should see it.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  logic             clk_i;
  logic             rst_ni           = 1'b0;
  logic             cfg_valid_i      = 1'b0;
  logic             cfg_ready_o;
  logic [AddrW-1:0] cfg_data_i       = '0;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic             operation_i      = 1'b0;
  logic [7:0]       byte_value_i     = '0;
  logic [CntW-1:0]  param_count_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic [7:0]       tx_byte_o;
  logic             last_of_packet_o;

  // Beats waiting to be driven, and packet bytes waiting to be received.
  framer_beat_t beats_todo[$];
  pkt_byte_t    bytes_due[$];

  // Framing state of the bench model: address, open packet, bytes still
  // owed to it and the running checksum.
  logic [AddrW-1:0] frm_addr = AddrReset;
  logic             frm_open = 1'b0;
  logic [CntW-1:0]  frm_left = '0;
  logic [SumW-1:0]  frm_sum  = '0;

  int  mismatches = 0;
  int  bytes_seen = 0;
  int  tx_wait    = 0;
  int  rx_hold    = 0;
  bit  tx_steady  = 1'b0;
  bit  rx_steady  = 1'b0;

  fingerprint_command_packet_framer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .byte_value_i     (byte_value_i),
    .param_count_i    (param_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tx_byte_o        (tx_byte_o),
    .last_of_packet_o (last_of_packet_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The run is cut short here if the block stops making progress.
  initial begin
    #4_000_000;
    $display("tb_fingerprint_command_packet_framer: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch at byte %0d: %s", $realtime, bytes_seen, what);
    mismatches++;
  endtask

  // Gap length in cycles. In a steady stretch there is no gap at all;
  // otherwise most gaps are short and a few are long.
  function automatic int idle_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic due_byte(input logic [7:0] data, input logic last);
    pkt_byte_t b;
    b.data = data;
    b.last = last;
    bytes_due.push_back(b);
  endtask

  task automatic close_packet();
    due_byte(frm_sum[15:8], 1'b0);
    due_byte(frm_sum[7:0], 1'b1);
    frm_open = 1'b0;
    frm_left = '0;
  endtask

  // Bench model: works out the packet bytes that one accepted beat causes.
  task automatic frame_beat(input fcpf_op_e op, input logic [7:0] val,
                            input logic [CntW-1:0] cnt);
    logic [CntW-1:0] n;
    logic [15:0]     flen;
    if (op == OP_START) begin
      // Counts over the limit are clipped, in the length field too. A start
      // simply abandons any packet that is still open.
      n    = (cnt > MaxParams) ? CntW'(MaxParams) : cnt;
      flen = 16'(n) + 16'd3;
      due_byte(HdrHi, 1'b0);
      due_byte(HdrLo, 1'b0);
      due_byte(frm_addr[31:24], 1'b0);
      due_byte(frm_addr[23:16], 1'b0);
      due_byte(frm_addr[15:8], 1'b0);
      due_byte(frm_addr[7:0], 1'b0);
      due_byte(CmdFlag, 1'b0);
      due_byte(flen[15:8], 1'b0);
      due_byte(flen[7:0], 1'b0);
      due_byte(val, 1'b0);
      frm_sum  = 16'(CmdFlag) + 16'(flen[15:8]) + 16'(flen[7:0]) + 16'(val);
      frm_left = n;
      frm_open = 1'b1;
      if (n == 0) close_packet();
    end else if (frm_open) begin
      // Parameter bytes pass through; with no packet open they vanish.
      due_byte(val, 1'b0);
      frm_sum = frm_sum + 16'(val);
      if (frm_left != 0) frm_left = frm_left - 1'b1;
      if (frm_left == 0) close_packet();
    end
  endtask

  // Input driver. The model runs on each accepted beat; a new beat is only
  // presented once the current one is gone, so valid never drops early.
  always @(posedge clk_i) begin : in_side
    framer_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        frame_beat(fcpf_op_e'(operation_i), byte_value_i, param_count_i);
      end
      if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
      if (!in_valid_i || in_ready_o) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (beats_todo.size() != 0) begin
          nxt = beats_todo.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= nxt.op;
          byte_value_i  <= nxt.val;
          param_count_i <= nxt.cnt;
          tx_wait = idle_gap(tx_steady);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stalls. Every byte taken is held against
  // the oldest expected one, field by field.
  always @(posedge clk_i) begin : out_side
    pkt_byte_t due;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", tx_byte_o));
        end else begin
          due = bytes_due.pop_front();
          if (tx_byte_o !== due.data) begin
            report_mismatch($sformatf("tx_byte %02h, expected %02h", tx_byte_o, due.data));
          end
          if (last_of_packet_o !== due.last) begin
            report_mismatch($sformatf("last_of_packet %b, expected %b",
                                      last_of_packet_o, due.last));
          end
        end
        bytes_seen++;
      end
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_hold = idle_gap(rx_steady);
      end
    end
  end

  task automatic queue_beat(input fcpf_op_e op, input logic [7:0] val,
                            input logic [CntW-1:0] cnt);
    framer_beat_t b;
    b.op  = op;
    b.val = val;
    b.cnt = cnt;
    beats_todo.push_back(b);
  endtask

  // A start followed by nparams parameter beats of random content. The
  // count field of a parameter beat is ignored, so it is random as well.
  task automatic queue_packet(input int cnt, input int nparams);
    bit all_ones;
    all_ones = ($urandom_range(0, 9) == 0);
    queue_beat(OP_START, 8'($urandom_range(0, 255)), CntW'(cnt));
    repeat (nparams) begin
      queue_beat(OP_PARAM, all_ones ? 8'hFF : 8'($urandom_range(0, 255)),
                 CntW'($urandom_range(0, 63)));
    end
  endtask

  // Mostly small counts, some up to the limit, a few past it.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, MaxParams);
    return $urandom_range(MaxParams + 1, 63);
  endfunction

  function automatic int clipped(input int cnt);
    return (cnt > MaxParams) ? MaxParams : cnt;
  endfunction

  // Random phase: mostly complete packets, some cut short by the next start,
  // some stray parameter beats. It always ends on a complete packet so that
  // no packet is left open across an address change.
  task automatic random_traffic(input int target);
    int made;
    int kind;
    int cnt;
    int nsend;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      cnt  = pick_count();
      if (kind < 78) begin
        queue_packet(cnt, clipped(cnt));
        made += 1 + clipped(cnt);
      end else if (kind < 90) begin
        if (cnt == 0) cnt = 1;
        nsend = $urandom_range(0, clipped(cnt) - 1);
        queue_packet(cnt, nsend);
        made += 1 + nsend;
      end else begin
        // These count nothing toward the phase size: outside a packet the
        // block just drops them.
        repeat ($urandom_range(1, 3)) begin
          queue_beat(OP_PARAM, 8'($urandom_range(0, 255)), CntW'($urandom_range(0, 63)));
        end
      end
    end
    cnt = pick_count();
    queue_packet(cnt, clipped(cnt));
  endtask

  // Waits until every beat is sent and every byte received, then gives the
  // block time to swallow any stray beats that left nothing behind.
  task automatic drain();
    while (beats_todo.size() != 0 || in_valid_i || bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [AddrW-1:0] addr);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    frm_addr = addr;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [AddrW-1:0] addr_plan[5];
    addr_plan[0] = 32'h0000_0000;
    addr_plan[1] = AddrW'($urandom);
    addr_plan[2] = 32'hFFFF_FFFF;
    addr_plan[3] = 32'h8000_0001;
    addr_plan[4] = AddrW'($urandom);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset address.
    // A parameter beat straight after reset has no packet to join.
    queue_beat(OP_PARAM, 8'hA5, 6'd0);
    // Zero counts close at once, with the command byte at both extremes.
    queue_beat(OP_START, 8'h00, 6'd0);
    queue_beat(OP_START, 8'hFF, 6'd0);
    // Stray beat after a closed packet, with all count bits set.
    queue_beat(OP_PARAM, 8'h55, 6'd63);
    // Short packet with the parameter byte at both extremes.
    queue_beat(OP_START, 8'h12, 6'd2);
    queue_beat(OP_PARAM, 8'h00, 6'd0);
    queue_beat(OP_PARAM, 8'hFF, 6'd0);
    // A new start abandons an open packet without a checksum.
    queue_beat(OP_START, 8'h34, 6'd3);
    queue_beat(OP_PARAM, 8'hAA, 6'd0);
    queue_beat(OP_START, 8'h56, 6'd1);
    queue_beat(OP_PARAM, 8'h5A, 6'd0);
    // Counts past the limit: the length field is clipped.
    queue_beat(OP_START, 8'h80, 6'd63);
    queue_beat(OP_PARAM, 8'hFF, 6'd0);
    queue_beat(OP_PARAM, 8'h7F, 6'd0);
    queue_beat(OP_START, 8'h01, 6'd33);
    queue_beat(OP_PARAM, 8'h01, 6'd0);
    // Exactly at the limit, abandoned below by a single byte packet.
    queue_beat(OP_START, 8'hC3, 6'd32);
    queue_beat(OP_START, 8'h3C, 6'd1);
    queue_beat(OP_PARAM, 8'h99, 6'd21);
    queue_beat(OP_PARAM, 8'h66, 6'd42);
    drain();

    // Random traffic under a sequence of device addresses.
    foreach (addr_plan[i]) begin
      write_address(addr_plan[i]);
      random_traffic(50);
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_fingerprint_command_packet_framer: done, clean");
    end else begin
      $display("tb_fingerprint_command_packet_framer: done, errors");
    end
    $finish;
  end

endmodule
